FILE: src/chol3_pkg.sv
// ----------------------------------------------------------------------------
// chol3_pkg
// Shared widths, latencies, status codes and pipeline records for the 3x3
// fixed-point Cholesky factor core.
// ----------------------------------------------------------------------------
package chol3_pkg;

	localparam int FRAC      = 24;
	localparam int L_W       = 32;
	localparam int LD_W      = 31;
	localparam int DIAG_W    = 28;
	localparam int X_W       = 2 * DIAG_W;
	localparam int P_W       = X_W - FRAC - 1;
	localparam int SQ_REM_W  = DIAG_W + 2;
	localparam int SQ_STEPS  = DIAG_W;
	localparam int SQ_LAT    = SQ_STEPS + 1;
	localparam int NUM_W     = 64;
	localparam int Q_W       = L_W + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int DIV_LAT   = DIV_STEPS + 3;
	localparam int PIPE_LAT  = 3 * SQ_LAT + 2 * DIV_LAT + 13;
	localparam int DATA_W    = 192;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NONPOS = 2'd1,
		ST_ROOT0  = 2'd2,
		ST_OVF    = 2'd3
	} status_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [DIAG_W-1:0]   root;
		logic [X_W-1:0]      xs;
	} sq_t;

	typedef struct packed {
		logic [DIAG_W-1:0] rem;
		logic [Q_W-1:0]    nl;
		logic [Q_W-1:0]    q;
		logic [DIAG_W-1:0] d;
		logic              neg;
		logic              ovf;
	} dv_t;

	typedef struct packed {
		logic signed [L_W-1:0]   m10;
		logic signed [L_W-1:0]   m11;
		logic signed [L_W-1:0]   m20;
		logic signed [L_W-1:0]   m21;
		logic signed [L_W-1:0]   m22;
		logic [DIAG_W-1:0]       l00;
		logic [DIAG_W-1:0]       l11;
		logic [DIAG_W-1:0]       l22;
		logic signed [L_W-1:0]   l10;
		logic signed [L_W-1:0]   l20;
		logic signed [L_W-1:0]   l21;
		logic signed [NUM_W-1:0] acc21;
		logic signed [NUM_W-1:0] acc22a;
		status_t                 c00;
		status_t                 c10;
		status_t                 c11;
		status_t                 c20;
		status_t                 c21;
		status_t                 c22;
	} item_t;

endpackage

FILE: src/cholesky_3x3_factor_core.sv
// ----------------------------------------------------------------------------
// cholesky_3x3_factor_core
// Pipelined Cholesky factor of a symmetric 3x3 Q8.24 matrix with status.
//
// channel  dir  tdata                                   tuser
// s_*      in   m00 m10 m11 m20 m21 m22 (32b each)      -
// m_*      out  l00(31) l10 l11(31) l20 l21 l22(31) pad status(2)
//
// One matrix per cycle while no result waits at the output.
// The pipe chains three root units (28 digit cells each) and two ranks of divider
// units (33 quotient cells each) in series; the first rank holds two units.
// The whole pipe advances together; it holds only while a result waits.
// Reset clears the valid line; data registers are not reset.
// ----------------------------------------------------------------------------
module cholesky_3x3_factor_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // m00, m10, m11, m20, m21, m22
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // l00, l10, l11, l20, l21, l22, 3b zero
	output logic [1:0]   m_tuser    // status
);

	localparam int PL  = chol3_pkg::PIPE_LAT;
	localparam int SQL = chol3_pkg::SQ_LAT;
	localparam int DVL = chol3_pkg::DIV_LAT;
	localparam int LW  = chol3_pkg::L_W;
	localparam int NW  = chol3_pkg::NUM_W;
	localparam int DW  = chol3_pkg::DIAG_W;
	localparam int PW  = chol3_pkg::P_W;
	localparam int FR  = chol3_pkg::FRAC;
	localparam int LDW = chol3_pkg::LD_W;

	function automatic logic signed [NW-1:0] to_q48(input logic signed [LW-1:0] v);
		return {{(NW-LW-FR){v[LW-1]}}, v, {FR{1'b0}}};
	endfunction

	function automatic chol3_pkg::status_t pivot_code(input logic signed [NW:0] a);
		chol3_pkg::status_t c;
		if (a[NW] || a == '0) begin
			c = chol3_pkg::ST_NONPOS;
		end else if (a[NW:FR] == '0) begin
			c = chol3_pkg::ST_ROOT0;
		end else begin
			c = chol3_pkg::ST_OK;
		end
		return c;
	endfunction

	logic                 en;
	logic [PL-1:0]        vld_q;
	logic signed [LW-1:0] m00;
	chol3_pkg::item_t     it_in;

	chol3_pkg::item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	chol3_pkg::item_t it_s7, it_s8, it_s9, it_s10, it_s11, it_s12;
	chol3_pkg::item_t it_s2_nx, it_s3_nx, it_s5_nx, it_s6_nx;
	chol3_pkg::item_t it_s7_nx, it_s8_nx, it_s11_nx, it_s12_nx;
	chol3_pkg::item_t sqa_line_q [SQL];
	chol3_pkg::item_t sqb_line_q [SQL];
	chol3_pkg::item_t sqc_line_q [SQL];
	chol3_pkg::item_t dva_line_q [DVL];
	chol3_pkg::item_t dvb_line_q [DVL];

	logic [PW-1:0]        p00_s1, p11_s6, p22_s11;
	logic [DW-1:0]        root_a, root_b, root_c;
	logic signed [NW-1:0] acc10, acc20;
	logic signed [LW-1:0] quo_a, quo_b, quo_c;
	logic                 ovf_a, ovf_b, ovf_c;
	logic signed [NW-1:0] sq11_s4, pr21_s4, sq20_s4;
	logic signed [NW-1:0] acc11_s5;
	logic signed [NW-1:0] sq22_s9;
	logic signed [NW:0]   acc22_s10;

	chol3_pkg::status_t   st;
	logic [191:0]         tdata_q;
	chol3_pkg::status_t   tuser_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PL-2:0], s_tvalid};
		end
	end

	assign m00 = $signed(s_tdata[31:0]);

	always_comb begin
		it_in     = '0;
		it_in.m10 = $signed(s_tdata[63:32]);
		it_in.m11 = $signed(s_tdata[95:64]);
		it_in.m20 = $signed(s_tdata[127:96]);
		it_in.m21 = $signed(s_tdata[159:128]);
		it_in.m22 = $signed(s_tdata[191:160]);
		it_in.c00 = (m00[LW-1] || m00 == '0) ? chol3_pkg::ST_NONPOS : chol3_pkg::ST_OK;
		it_in.c10 = chol3_pkg::ST_OK;
		it_in.c11 = chol3_pkg::ST_OK;
		it_in.c20 = chol3_pkg::ST_OK;
		it_in.c21 = chol3_pkg::ST_OK;
		it_in.c22 = chol3_pkg::ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= it_in;
			p00_s1 <= m00[PW-1:0];
		end
	end

	// column 0 diagonal
	chol3_sqrt_unit u_sqa (.clk(clk), .en(en), .p(p00_s1), .root(root_a));

	always_comb begin
		it_s2_nx     = sqa_line_q[SQL-1];
		it_s2_nx.l00 = root_a;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_line_q[0] <= it_s1;
			for (int i = 1; i < SQL; i++) sqa_line_q[i] <= sqa_line_q[i-1];
			it_s2 <= it_s2_nx;
		end
	end

	// column 0 off-diagonals
	assign acc10 = to_q48(it_s2.m10);
	assign acc20 = to_q48(it_s2.m20);

	chol3_div_unit u_dva (
		.clk(clk), .en(en), .acc(acc10), .d(it_s2.l00), .quo(quo_a), .ovf(ovf_a)
	);
	chol3_div_unit u_dvb (
		.clk(clk), .en(en), .acc(acc20), .d(it_s2.l00), .quo(quo_b), .ovf(ovf_b)
	);

	always_comb begin
		it_s3_nx     = dva_line_q[DVL-1];
		it_s3_nx.l10 = quo_a;
		it_s3_nx.l20 = quo_b;
		it_s3_nx.c10 = ovf_a ? chol3_pkg::ST_OVF : chol3_pkg::ST_OK;
		it_s3_nx.c20 = ovf_b ? chol3_pkg::ST_OVF : chol3_pkg::ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dva_line_q[0] <= it_s2;
			for (int i = 1; i < DVL; i++) dva_line_q[i] <= dva_line_q[i-1];
			it_s3 <= it_s3_nx;
		end
	end

	always_comb begin
		it_s5_nx        = it_s4;
		it_s5_nx.acc21  = to_q48(it_s4.m21) - pr21_s4;
		it_s5_nx.acc22a = to_q48(it_s4.m22) - sq20_s4;
		it_s6_nx        = it_s5;
		it_s6_nx.c11    = pivot_code({acc11_s5[NW-1], acc11_s5});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4   <= it_s3;
			sq11_s4 <= $signed(it_s3.l10) * $signed(it_s3.l10);
			pr21_s4 <= $signed(it_s3.l20) * $signed(it_s3.l10);
			sq20_s4 <= $signed(it_s3.l20) * $signed(it_s3.l20);

			it_s5    <= it_s5_nx;
			acc11_s5 <= to_q48(it_s4.m11) - sq11_s4;

			it_s6  <= it_s6_nx;
			p11_s6 <= acc11_s5[FR+PW-1:FR];
		end
	end

	// column 1 diagonal
	chol3_sqrt_unit u_sqb (.clk(clk), .en(en), .p(p11_s6), .root(root_b));

	always_comb begin
		it_s7_nx     = sqb_line_q[SQL-1];
		it_s7_nx.l11 = root_b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqb_line_q[0] <= it_s6;
			for (int i = 1; i < SQL; i++) sqb_line_q[i] <= sqb_line_q[i-1];
			it_s7 <= it_s7_nx;
		end
	end

	chol3_div_unit u_dvc (
		.clk(clk), .en(en), .acc(it_s7.acc21), .d(it_s7.l11), .quo(quo_c), .ovf(ovf_c)
	);

	always_comb begin
		it_s8_nx     = dvb_line_q[DVL-1];
		it_s8_nx.l21 = quo_c;
		it_s8_nx.c21 = ovf_c ? chol3_pkg::ST_OVF : chol3_pkg::ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvb_line_q[0] <= it_s7;
			for (int i = 1; i < DVL; i++) dvb_line_q[i] <= dvb_line_q[i-1];
			it_s8 <= it_s8_nx;
		end
	end

	always_comb begin
		it_s11_nx     = it_s10;
		it_s11_nx.c22 = pivot_code(acc22_s10);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s9   <= it_s8;
			sq22_s9 <= $signed(it_s8.l21) * $signed(it_s8.l21);

			it_s10    <= it_s9;
			acc22_s10 <= {it_s9.acc22a[NW-1], it_s9.acc22a} - {sq22_s9[NW-1], sq22_s9};

			it_s11  <= it_s11_nx;
			p22_s11 <= acc22_s10[FR+PW-1:FR];
		end
	end

	// column 2 diagonal
	chol3_sqrt_unit u_sqc (.clk(clk), .en(en), .p(p22_s11), .root(root_c));

	always_comb begin
		it_s12_nx     = sqc_line_q[SQL-1];
		it_s12_nx.l22 = root_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqc_line_q[0] <= it_s11;
			for (int i = 1; i < SQL; i++) sqc_line_q[i] <= sqc_line_q[i-1];
			it_s12 <= it_s12_nx;
		end
	end

	// first failing entry in row order wins
	always_comb begin
		if (it_s12.c00 != chol3_pkg::ST_OK) begin
			st = it_s12.c00;
		end else if (it_s12.c10 != chol3_pkg::ST_OK) begin
			st = it_s12.c10;
		end else if (it_s12.c11 != chol3_pkg::ST_OK) begin
			st = it_s12.c11;
		end else if (it_s12.c20 != chol3_pkg::ST_OK) begin
			st = it_s12.c20;
		end else if (it_s12.c21 != chol3_pkg::ST_OK) begin
			st = it_s12.c21;
		end else begin
			st = it_s12.c22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tuser_q <= st;
			if (st == chol3_pkg::ST_OK) begin
				tdata_q <= {3'b000, LDW'(it_s12.l22), it_s12.l21, it_s12.l20,
					LDW'(it_s12.l11), it_s12.l10, LDW'(it_s12.l00)};
			end else begin
				tdata_q <= '0;
			end
		end
	end

	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != chol3_pkg::ST_OK) |-> (m_tdata == '0))
		else $error("failed factor carries nonzero entries");

	a_ok_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == chol3_pkg::ST_OK) |->
		(m_tdata[30:0] != '0 && m_tdata[93:63] != '0 && m_tdata[188:158] != '0))
		else $error("good factor with zero diagonal");

	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[30:28] == '0 && m_tdata[93:91] == '0 &&
		m_tdata[188:186] == '0 && m_tdata[191:189] == '0))
		else $error("diagonal root out of range");

endmodule

FILE: src/chol3_sqrt_cell.sv
// ----------------------------------------------------------------------------
// chol3_sqrt_cell
// One digit step of the restoring square root: takes two radicand bits,
// produces one root bit, registered.
// ----------------------------------------------------------------------------
module chol3_sqrt_cell (
	input  logic            clk,
	input  logic            en,
	input  chol3_pkg::sq_t  d_in,
	output chol3_pkg::sq_t  d_out
);

	localparam int RW = chol3_pkg::SQ_REM_W;
	localparam int DW = chol3_pkg::DIAG_W;
	localparam int XW = chol3_pkg::X_W;

	logic [RW+1:0]  part;
	logic [RW+1:0]  trial;
	logic [RW+1:0]  diff;
	logic           ge;
	chol3_pkg::sq_t nxt;

	always_comb begin
		part     = {d_in.rem, d_in.xs[XW-1 -: 2]};
		trial    = {2'b00, d_in.root, 2'b01};
		diff     = part - trial;
		ge       = (part >= trial);
		nxt.rem  = ge ? diff[RW-1:0] : part[RW-1:0];
		nxt.root = {d_in.root[DW-2:0], ge};
		nxt.xs   = {d_in.xs[XW-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

FILE: src/chol3_div_cell.sv
// ----------------------------------------------------------------------------
// chol3_div_cell
// One quotient bit of the restoring divider, registered.
// ----------------------------------------------------------------------------
module chol3_div_cell (
	input  logic            clk,
	input  logic            en,
	input  chol3_pkg::dv_t  d_in,
	output chol3_pkg::dv_t  d_out
);

	localparam int DW = chol3_pkg::DIAG_W;
	localparam int QW = chol3_pkg::Q_W;

	logic [DW:0]    t;
	logic [DW:0]    diff;
	logic           ge;
	chol3_pkg::dv_t nxt;

	always_comb begin
		t       = {d_in.rem, d_in.nl[QW-1]};
		diff    = t - {1'b0, d_in.d};
		ge      = (t >= {1'b0, d_in.d});
		nxt     = d_in;
		nxt.rem = ge ? diff[DW-1:0] : t[DW-1:0];
		nxt.nl  = {d_in.nl[QW-2:0], 1'b0};
		nxt.q   = {d_in.q[QW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

FILE: src/chol3_sqrt_unit.sv
// ----------------------------------------------------------------------------
// chol3_sqrt_unit
// Rounded square root of an unsigned Q7.24 pivot: a chain of digit cells
// followed by a round-to-nearest stage.
// ----------------------------------------------------------------------------
module chol3_sqrt_unit (
	input  logic                           clk,
	input  logic                           en,
	input  logic [chol3_pkg::P_W-1:0]      p,
	output logic [chol3_pkg::DIAG_W-1:0]   root
);

	localparam int N  = chol3_pkg::SQ_STEPS;
	localparam int DW = chol3_pkg::DIAG_W;
	localparam int RW = chol3_pkg::SQ_REM_W;

	chol3_pkg::sq_t    link [N+1];
	chol3_pkg::sq_t    fin;
	logic              up;
	logic [DW-1:0]     root_q;

	always_comb begin
		link[0].rem  = '0;
		link[0].root = '0;
		link[0].xs   = {1'b0, p, {chol3_pkg::FRAC{1'b0}}};
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		chol3_sqrt_cell u_cell (
			.clk   (clk),
			.en    (en),
			.d_in  (link[k]),
			.d_out (link[k+1])
		);
	end

	// remainder above the floor root rounds up
	always_comb begin
		fin = link[N];
		up  = (fin.rem > RW'(fin.root));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= fin.root + DW'(up);
		end
	end

	assign root = root_q;

endmodule

FILE: src/chol3_div_unit.sv
// ----------------------------------------------------------------------------
// chol3_div_unit
// Signed Q16.48 numerator over unsigned Q4.24 divisor, rounded half away from
// zero, with range check against the signed 32-bit result.
// ----------------------------------------------------------------------------
module chol3_div_unit (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [chol3_pkg::NUM_W-1:0]  acc,
	input  logic [chol3_pkg::DIAG_W-1:0]        d,
	output logic signed [chol3_pkg::L_W-1:0]    quo,
	output logic                                ovf
);

	localparam int N  = chol3_pkg::DIV_STEPS;
	localparam int NW = chol3_pkg::NUM_W;
	localparam int QW = chol3_pkg::Q_W;
	localparam int DW = chol3_pkg::DIAG_W;
	localparam int LW = chol3_pkg::L_W;
	localparam int HW = NW - QW;
	localparam logic [QW-1:0] NEG_MAX = QW'(1) << (LW - 1);
	localparam logic [QW-1:0] POS_MAX = NEG_MAX - QW'(1);

	logic [NW-1:0]     au;
	logic [NW-1:0]     half;
	logic [NW-1:0]     num_s1;
	logic [DW-1:0]     d_s1;
	logic              neg_s1;
	logic [HW-1:0]     hi;
	chol3_pkg::dv_t    link [N+1];
	chol3_pkg::dv_t    fin;
	logic [QW-1:0]     lim;
	logic [QW-1:0]     qs;
	logic signed [LW-1:0] quo_q;
	logic              ovf_q;

	assign au   = acc;
	assign half = NW'(d >> 1);

	// magnitude plus half divisor in one adder
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= acc[NW-1] ? (half - au) : (au + half);
			d_s1   <= d;
			neg_s1 <= acc[NW-1];
		end
	end

	assign hi = num_s1[NW-1:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			link[0].rem <= hi[DW-1:0];
			link[0].nl  <= num_s1[QW-1:0];
			link[0].q   <= '0;
			link[0].d   <= d_s1;
			link[0].neg <= neg_s1;
			link[0].ovf <= (hi >= HW'(d_s1));
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		chol3_div_cell u_cell (
			.clk   (clk),
			.en    (en),
			.d_in  (link[k]),
			.d_out (link[k+1])
		);
	end

	always_comb begin
		fin = link[N];
		lim = fin.neg ? NEG_MAX : POS_MAX;
		qs  = fin.neg ? (~fin.q + QW'(1)) : fin.q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= qs[LW-1:0];
			ovf_q <= fin.ovf || (fin.q > lim);
		end
	end

	assign quo = quo_q;
	assign ovf = ovf_q;

endmodule
